### rtl/core/qtl_pkg.sv
package qtl_pkg;

    // Table geometry (both counts are powers of two)
    localparam int NUM_STATES = 1024;
    localparam int NUM_MOVES  = 16;
    localparam int ROW_W      = $clog2(NUM_STATES);
    localparam int COL_W      = $clog2(NUM_MOVES);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH      = NUM_STATES * NUM_MOVES;
    localparam int CNT_W      = $clog2(NUM_MOVES + 1);

    // Field widths
    localparam int STATE_FW = 10;
    localparam int MOVE_FW  = 4;
    localparam int MASK_W   = 16;
    localparam int PICK_W   = 16;
    localparam int PICK_IW  = $clog2(PICK_W);
    localparam int GAIN_W   = 17;
    localparam int Q_W      = 32;

    // Arithmetic widths
    localparam int PROD_W = 53;
    localparam int TD_W   = 35;
    localparam int SUM_W  = PROD_W - 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [MASK_W-1:0] MOVE_MASK = MASK_W'((64'd1 << NUM_MOVES) - 64'd1);

    // Configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_LEARN_RATE   = 2'd0;
    localparam logic [1:0] REG_DISCOUNT     = 2'd1;
    localparam logic [1:0] REG_EXPLORE_RATE = 2'd2;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_ADD    = 3'd2,
        ACT_LEARN  = 3'd3,
        ACT_SELECT = 3'd4,
        ACT_CLEAR  = 3'd5
    } act_t;

    typedef enum logic [3:0] {
        S_WIPE,
        S_IDLE,
        S_DISPATCH,
        S_MOD,
        S_SCAN,
        S_FETCH,
        S_OLD,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]          action;
        logic [STATE_FW-1:0] state_index;
        logic [MOVE_FW-1:0]  move;
        logic [STATE_FW-1:0] next_state_index;
        logic signed [31:0]  value;
        logic signed [31:0]  reward;
        logic [MASK_W-1:0]   valid_moves;
        logic [15:0]         random_draw;
        logic [PICK_W-1:0]   random_pick;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] q_value;
        logic [3:0]         chosen_move;
        logic               explored;
        logic               no_valid_move;
    } out_resp_t;

    // Row of the table from a state field
    function automatic logic [ROW_W-1:0] row_of(input logic [STATE_FW-1:0] f);
        logic [ROW_W+STATE_FW-1:0] t;
        t = {{ROW_W{1'b0}}, f};
        return t[ROW_W-1:0];
    endfunction

    // Nearest, ties up: floor((p + 32768) / 65536)
    function automatic logic signed [SUM_W-1:0] round_frac(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return t[PROD_W-1:16];
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SUM_W'(64'sd2147483647))
            r = 32'sh7fffffff;
        else if (v < -SUM_W'(64'sd2147483648))
            r = 32'sh80000000;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [31:0] v);
        logic [GAIN_W-1:0] r;
        r = v[GAIN_W-1:0];
        if (r > GAIN_ONE)
            r = GAIN_ONE;
        return r;
    endfunction

endpackage

### rtl/core/qtl_ram.sv
module qtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/q_table_learn_and_select.sv
// Q-table learner with epsilon-greedy move selection.
// Requests come in on in_data with in_valid/in_stall; one response per
// request leaves on out_data with out_valid/out_stall. Gains sit in three
// APB registers (learn rate, discount, explore rate at 0x0, 0x4, 0x8).
// The Q table lives in one single-port-read, single-port-write RAM; the
// sequencer handles one request at a time, reading one entry per cycle.
// Work done per request:
//   read, write, add        one entry read, then the response
//   learn                   16-entry row scan, two multiplies
//   select, greedy          16-entry row scan
//   select, explore         16-step remainder, then the scan
//   clear                   all 16384 entries, one entry written per cycle
// The registered RAM read port sets the scan length.
// After reset every table entry is swept to zero; in_stall stays
// high meanwhile, while APB writes are taken as ever.
// The response sits in an output register; while out_stall holds, the next
// request is accepted and worked on, and only its final step waits.
module q_table_learn_and_select
    import qtl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_req_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_resp_t        out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0] learn_rate_reg, discount_reg, explore_rate_reg;

    in_req_t                  req_reg;
    logic [ADDR_W-1:0]        wipe_cnt_reg;
    logic                     wipe_resp_reg;
    logic [ROW_W-1:0]         scan_row_reg;
    logic [COL_W:0]           scan_cnt_reg;
    logic                     pend_reg;
    logic [COL_W-1:0]         pend_col_reg;
    logic                     have_reg;
    logic signed [Q_W-1:0]    best_reg;
    logic [COL_W-1:0]         best_col_reg;
    logic                     explore_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [PICK_IW-1:0]       mod_cnt_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    old_reg;
    logic signed [TD_W-1:0]   td_reg;
    logic signed [Q_W-1:0]    res_q_reg;
    logic [3:0]               res_move_reg;
    logic                     res_expl_reg;
    logic                     res_none_reg;
    out_resp_t                out_reg;
    logic                     out_valid_reg;

    logic                     ram_we, ram_re;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [Q_W-1:0]           ram_wdata, ram_rdata;
    logic signed [Q_W-1:0]    rd_q;

    logic [ADDR_W-1:0]        pos;
    logic [MASK_W-1:0]        mask_m;
    logic [CNT_W-1:0]         pop;
    logic                     slot_free;
    logic                     scan_done;
    logic                     writes_entry;
    logic [CNT_W:0]           rem_shift;
    logic [CNT_W-1:0]         rem_new;
    logic signed [49:0]       prod_g;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [SUM_W-1:0]  g_rnd, d_rnd;
    logic signed [SUM_W-1:0]  add_sum;

    assign rd_q         = ram_rdata;
    assign pos          = {row_of(req_reg.state_index), req_reg.move[COL_W-1:0]};
    assign mask_m       = req_reg.valid_moves & MOVE_MASK;
    assign slot_free    = !out_valid_reg || !out_stall;
    assign scan_done    = (scan_cnt_reg == (COL_W+1)'(NUM_MOVES)) && !pend_reg;
    assign writes_entry = (req_reg.action == ACT_WRITE) || (req_reg.action == ACT_ADD)
                          || (req_reg.action == ACT_LEARN);

    // Popcount of the mask
    always_comb
    begin
        pop = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            pop = pop + CNT_W'(mask_m[i]);
        end
    end

    // One restoring step of random_pick mod count
    assign rem_shift = {rem_reg, req_reg.random_pick[mod_cnt_reg]};
    assign rem_new   = (rem_shift >= {1'b0, count_reg}) ?
                       CNT_W'(rem_shift - {1'b0, count_reg}) : CNT_W'(rem_shift);

    // Arithmetic
    assign prod_g  = $signed({1'b0, discount_reg}) * best_reg;
    assign prod_d  = $signed({1'b0, learn_rate_reg}) * td_reg;
    assign g_rnd   = round_frac(prod_reg);
    assign d_rnd   = round_frac(prod_reg);
    assign add_sum = SUM_W'(rd_q) + SUM_W'(req_reg.value);

    // Table memory
    qtl_ram #(
        .WIDTH (Q_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_WIPE:
            begin
                if (wipe_cnt_reg == ADDR_W'(DEPTH - 1))
                    state_next = wipe_resp_reg ? S_OUT : S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (req_reg.action)
                    ACT_READ, ACT_WRITE, ACT_ADD: state_next = S_FETCH;
                    ACT_LEARN:                    state_next = S_SCAN;
                    ACT_SELECT:
                    begin
                        if (pop == '0)
                            state_next = S_OUT;
                        else if ({1'b0, req_reg.random_draw} < explore_rate_reg)
                            state_next = S_MOD;
                        else
                            state_next = S_SCAN;
                    end
                    ACT_CLEAR:                    state_next = S_WIPE;
                    default:                      state_next = S_OUT;
                endcase
            end
            S_MOD:
            begin
                if (mod_cnt_reg == '0)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = (req_reg.action == ACT_LEARN) ? S_FETCH : S_OUT;
            end
            S_FETCH: state_next = S_OLD;
            S_OLD:   state_next = (req_reg.action == ACT_LEARN) ? S_MUL : S_OUT;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_OUT;
            S_OUT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and RAM controls
    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = pos;
        ram_wdata = res_q_reg;
        ram_re    = 1'b0;
        ram_raddr = pos;
        case (state_reg)
            S_WIPE:
            begin
                ram_we    = 1'b1;
                ram_waddr = wipe_cnt_reg;
                ram_wdata = '0;
            end
            S_IDLE:  in_stall = 1'b0;
            S_SCAN:
            begin
                ram_re    = scan_cnt_reg < (COL_W+1)'(NUM_MOVES);
                ram_raddr = {scan_row_reg, scan_cnt_reg[COL_W-1:0]};
            end
            S_FETCH: ram_re = 1'b1;
            S_OUT:   ram_we = slot_free && writes_entry;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            wipe_cnt_reg  <= '0;
            wipe_resp_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Clear sweep counter
            if (state_reg == S_WIPE)
                wipe_cnt_reg <= wipe_cnt_reg + ADDR_W'(1);
            else if (state_reg == S_DISPATCH)
            begin
                wipe_cnt_reg  <= '0;
                wipe_resp_reg <= 1'b1;
            end

            // Read pending in the scan
            pend_reg <= (state_reg == S_SCAN) && (scan_cnt_reg < (COL_W+1)'(NUM_MOVES));

            // Output register
            if (state_reg == S_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_reg <= in_data;
            end
            S_DISPATCH:
            begin
                res_q_reg    <= '0;
                res_move_reg <= req_reg.move;
                res_expl_reg <= 1'b0;
                res_none_reg <= 1'b0;
                have_reg     <= 1'b0;
                scan_cnt_reg <= '0;
                count_reg    <= pop;
                rem_reg      <= '0;
                mod_cnt_reg  <= PICK_IW'(PICK_W - 1);
                k_reg        <= '0;
                explore_reg  <= {1'b0, req_reg.random_draw} < explore_rate_reg;
                scan_row_reg <= (req_reg.action == ACT_LEARN) ?
                                row_of(req_reg.next_state_index) :
                                row_of(req_reg.state_index);
                if (req_reg.action == ACT_SELECT && pop == '0)
                begin
                    res_move_reg <= '0;
                    res_none_reg <= 1'b1;
                end
            end
            S_MOD:
            begin
                rem_reg     <= rem_new;
                k_reg       <= rem_new;
                mod_cnt_reg <= mod_cnt_reg - PICK_IW'(1);
            end
            S_SCAN:
            begin
                if (scan_cnt_reg < (COL_W+1)'(NUM_MOVES))
                begin
                    scan_cnt_reg <= scan_cnt_reg + (COL_W+1)'(1);
                    pend_col_reg <= scan_cnt_reg[COL_W-1:0];
                end
                // Process the entry read last cycle
                if (pend_reg)
                begin
                    if (req_reg.action == ACT_LEARN)
                    begin
                        if (!have_reg || rd_q > best_reg)
                        begin
                            best_reg <= rd_q;
                            have_reg <= 1'b1;
                        end
                    end
                    else if (explore_reg)
                    begin
                        if (mask_m[pend_col_reg])
                        begin
                            if (k_reg == '0 && !have_reg)
                            begin
                                best_reg     <= rd_q;
                                best_col_reg <= pend_col_reg;
                                have_reg     <= 1'b1;
                            end
                            else if (k_reg != '0)
                                k_reg <= k_reg - CNT_W'(1);
                        end
                    end
                    else if (mask_m[pend_col_reg] && (!have_reg || rd_q > best_reg))
                    begin
                        best_reg     <= rd_q;
                        best_col_reg <= pend_col_reg;
                        have_reg     <= 1'b1;
                    end
                end
                if (scan_done && req_reg.action == ACT_SELECT)
                begin
                    res_q_reg    <= best_reg;
                    res_move_reg <= 4'(best_col_reg);
                    res_expl_reg <= explore_reg;
                end
            end
            S_FETCH:
            begin
                prod_reg <= PROD_W'(prod_g);
            end
            S_OLD:
            begin
                old_reg <= rd_q;
                td_reg  <= TD_W'(req_reg.reward) + g_rnd[TD_W-1:0] - TD_W'(rd_q);
                case (req_reg.action)
                    ACT_READ:  res_q_reg <= rd_q;
                    ACT_WRITE: res_q_reg <= req_reg.value;
                    ACT_ADD:   res_q_reg <= sat32(add_sum);
                    default:   ;
                endcase
            end
            S_MUL:
            begin
                prod_reg <= prod_d;
            end
            S_SUM:
            begin
                res_q_reg <= sat32(SUM_W'(old_reg) + d_rnd);
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_reg.q_value       <= res_q_reg;
                    out_reg.chosen_move   <= res_move_reg;
                    out_reg.explored      <= res_expl_reg;
                    out_reg.no_valid_move <= res_none_reg;
                end
            end
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg   <= GAIN_W'(6554);
            discount_reg     <= GAIN_W'(58982);
            explore_rate_reg <= GAIN_W'(6554);
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_LEARN_RATE:   learn_rate_reg   <= clamp_gain(pwdata);
                REG_DISCOUNT:     discount_reg     <= clamp_gain(pwdata);
                REG_EXPLORE_RATE: explore_rate_reg <= clamp_gain(pwdata);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LEARN_RATE:   prdata = 32'(learn_rate_reg);
            REG_DISCOUNT:     prdata = 32'(discount_reg);
            REG_EXPLORE_RATE: prdata = 32'(explore_rate_reg);
            default:          prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    // A response appears only from the final step of a request
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("response without a finished request");

    // An accepted request always starts its dispatch next
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_DISPATCH)
        else $error("accepted request not dispatched");

    // Explore and empty-mask flags are exclusive
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.explored && out_data.no_valid_move))
        else $error("explored and no_valid_move both set");

    // Table written only by a sweep or a finishing request
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_WIPE || state_reg == S_OUT))
        else $error("table write outside sweep or response");
`endif

endmodule

### test/q_table_learn_and_select_tb.sv
`timescale 1ns / 100ps

module q_table_learn_and_select_tb;
    import qtl_pkg::*;

    localparam int  TABLE_SIZE  = NUM_STATES * NUM_MOVES;
    localparam int  SETTLE_CYC  = 60;
    localparam longint CYC_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_req_t     in_data;
    logic        out_valid;
    logic        out_stall;
    out_resp_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    q_table_learn_and_select DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the table and the gains
    logic signed [31:0] q_shadow [TABLE_SIZE];
    longint alpha_g;
    longint gamma_g;
    longint eps_g;

    in_req_t   request_q [$];
    out_resp_t resp_q [$];

    int     send_idle;
    int     recv_idle;
    bit     send_hold;
    int     recv_hold_len;
    int     recv_hold_cnt;
    int     mismatch_cnt;
    longint cycle_cnt;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Nearest, ties toward plus infinity
    function automatic longint round_q16(input longint p);
        return (p + 32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint gain_of(input logic [31:0] v);
        longint g;
        g = longint'(v[16:0]);
        return (g > 65536) ? 65536 : g;
    endfunction

    // Expected response for one request; updates the shadow table
    function automatic out_resp_t q_predict(input in_req_t r);
        out_resp_t o;
        int     pos;
        int     nbase;
        int     cnt;
        int     k;
        longint best;
        longint g;
        longint td;
        longint d;
        bit     have;
        pos   = int'(r.state_index) * NUM_MOVES + int'(r.move);
        nbase = int'(r.next_state_index) * NUM_MOVES;
        o.q_value       = '0;
        o.chosen_move   = r.move;
        o.explored      = 1'b0;
        o.no_valid_move = 1'b0;
        case (r.action)
            ACT_READ:  o.q_value = q_shadow[pos];
            ACT_WRITE:
            begin
                q_shadow[pos] = r.value;
                o.q_value = r.value;
            end
            ACT_ADD:
            begin
                q_shadow[pos] = clip32(longint'(q_shadow[pos]) + longint'(r.value));
                o.q_value = q_shadow[pos];
            end
            ACT_LEARN:
            begin
                best = q_shadow[nbase];
                for (int i = 1; i < NUM_MOVES; i++)
                    if (q_shadow[nbase + i] > best)
                        best = q_shadow[nbase + i];
                g  = round_q16(gamma_g * best);
                td = longint'(r.reward) + g - longint'(q_shadow[pos]);
                d  = round_q16(alpha_g * td);
                q_shadow[pos] = clip32(longint'(q_shadow[pos]) + d);
                o.q_value = q_shadow[pos];
            end
            ACT_SELECT:
            begin
                cnt = $countones(r.valid_moves);
                o.chosen_move = '0;
                if (cnt == 0)
                    o.no_valid_move = 1'b1;
                else if (longint'(r.random_draw) < eps_g)
                begin
                    k = int'(r.random_pick) % cnt;
                    o.explored = 1'b1;
                    for (int i = 0; i < NUM_MOVES; i++)
                        if (r.valid_moves[i])
                        begin
                            if (k == 0)
                            begin
                                o.chosen_move = 4'(i);
                                break;
                            end
                            k--;
                        end
                    o.q_value = q_shadow[int'(r.state_index) * NUM_MOVES
                                         + int'(o.chosen_move)];
                end
                else
                begin
                    have = 1'b0;
                    for (int i = 0; i < NUM_MOVES; i++)
                        if (r.valid_moves[i])
                        begin
                            if (!have || q_shadow[int'(r.state_index) * NUM_MOVES + i]
                                         > o.q_value)
                            begin
                                o.q_value = q_shadow[int'(r.state_index) * NUM_MOVES + i];
                                o.chosen_move = 4'(i);
                                have = 1'b1;
                            end
                        end
                end
            end
            ACT_CLEAR:
                for (int i = 0; i < TABLE_SIZE; i++)
                    q_shadow[i] = '0;
            default: ;
        endcase
        return o;
    endfunction

    // Driver: offer pending requests, record accepted ones
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            resp_q.push_back(q_predict(in_data));
        if (!in_valid || !in_stall)
        begin
            if (request_q.size() > 0 && !send_hold && $urandom_range(99) >= send_idle)
            begin
                in_data  <= request_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (recv_hold_len > 0 && recv_hold_cnt == 0)
            recv_hold_cnt <= recv_hold_len;
        else if (recv_hold_cnt > 1)
            recv_hold_cnt <= recv_hold_cnt - 1;
        else if (recv_hold_cnt == 1)
        begin
            recv_hold_cnt <= 0;
            recv_hold_len <= 0;
        end
        out_stall <= (recv_hold_cnt > 1) || (recv_hold_len > 0 && recv_hold_cnt == 0)
                     || ($urandom_range(99) < recv_idle);
    end

    // Monitor: compare each response with the oldest expectation
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (resp_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected response %h", out_data);
            end
            else if (out_data !== resp_q[0])
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display({"response mismatch: expected q=%h mv=%0d ex=%b nv=%b,",
                              " got q=%h mv=%0d ex=%b nv=%b"},
                             resp_q[0].q_value, resp_q[0].chosen_move,
                             resp_q[0].explored, resp_q[0].no_valid_move,
                             out_data.q_value, out_data.chosen_move,
                             out_data.explored, out_data.no_valid_move);
                void'(resp_q.pop_front());
            end
            else
                void'(resp_q.pop_front());
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYC_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LEARN_RATE:   alpha_g = gain_of(v);
            REG_DISCOUNT:     gamma_g = gain_of(v);
            REG_EXPLORE_RATE: eps_g   = gain_of(v);
            default: ;
        endcase
    endtask

    // Wait until every request is sent and answered, then let the block settle
    task automatic wait_drained();
        while (request_q.size() > 0 || resp_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] q16_val();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(131071) - 65536;
            3: return 32'h7ff00000 + $urandom_range(65535) * 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] pick_row();
        return ($urandom_range(3) != 0) ? 10'($urandom_range(7)) : 10'($urandom);
    endfunction

    function automatic in_req_t rand_request();
        in_req_t r;
        int sel;
        r = '0;
        sel = $urandom_range(999);
        if (sel < 2)
            r.action = ACT_CLEAR;
        else if (sel < 20)
            r.action = 3'($urandom_range(6, 7));
        else if (sel < 120)
            r.action = ACT_READ;
        else if (sel < 300)
            r.action = ACT_WRITE;
        else if (sel < 450)
            r.action = ACT_ADD;
        else if (sel < 750)
            r.action = ACT_LEARN;
        else
            r.action = ACT_SELECT;
        r.state_index      = pick_row();
        r.next_state_index = pick_row();
        r.move             = 4'($urandom);
        r.value            = q16_val();
        r.reward           = q16_val();
        case ($urandom_range(5))
            0: r.valid_moves = '0;
            1: r.valid_moves = 16'hffff;
            2: r.valid_moves = 16'(1) << $urandom_range(15);
            default: r.valid_moves = 16'($urandom);
        endcase
        r.random_draw = 16'($urandom);
        r.random_pick = 16'($urandom);
        return r;
    endfunction

    function automatic in_req_t mk(input act_t a, input logic [9:0] s, input logic [3:0] m,
                                   input logic [9:0] ns, input logic [31:0] v,
                                   input logic [31:0] rw, input logic [15:0] mask,
                                   input logic [15:0] draw, input logic [15:0] pick);
        in_req_t r;
        r = '{a, s, m, ns, v, rw, mask, draw, pick};
        return r;
    endfunction

    initial
    begin
        int idle_tab [4][2];
        idle_tab = '{'{0, 0}, '{51, 0}, '{0, 51}, '{29, 29}};
        for (int i = 0; i < TABLE_SIZE; i++)
            q_shadow[i] = '0;
        alpha_g = 6554;
        gamma_g = 58982;
        eps_g   = 6554;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 0;
        recv_idle = 0;
        send_hold = 1'b0;
        recv_hold_len = 0;
        recv_hold_cnt = 0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset gains
        request_q.push_back(mk(ACT_READ, 10'd1023, 4'd15, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_WRITE, 10'd1023, 4'd15, 0, 32'h7fffffff, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_ADD, 10'd1023, 4'd15, 0, 32'h7fffffff, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_WRITE, 10'd0, 4'd0, 0, 32'h80000000, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_ADD, 10'd0, 4'd0, 0, 32'h80000000, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_READ, 10'd0, 4'd0, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_LEARN, 10'd1, 4'd3, 10'd1023, 0, 32'h7fffffff, 0, 0, 0));
        request_q.push_back(mk(ACT_LEARN, 10'd1, 4'd3, 10'd0, 0, 32'h80000000, 0, 0, 0));
        request_q.push_back(mk(ACT_LEARN, 10'd2, 4'd5, 10'd2, 0, 32'h00018000, 0, 0, 0));
        // ties on the greedy path go to the lowest valid move
        request_q.push_back(mk(ACT_WRITE, 10'd5, 4'd2, 0, 32'h00010000, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_WRITE, 10'd5, 4'd9, 0, 32'h00010000, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'hffff, 16'hffff, 0));
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'h0200, 16'hffff, 0));
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'h8001, 16'hffff, 0));
        // empty mask
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'h0000, 16'h0000, 0));
        // explore paths, and the greedy case at the explore-rate boundary
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'hffff, 16'h0000, 16'hffff));
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'h8204, 16'd6553, 16'd4));
        request_q.push_back(mk(ACT_SELECT, 10'd5, 4'd7, 0, 0, 0, 16'h8204, 16'd6554, 16'd4));
        // unused action codes
        request_q.push_back(mk(act_t'(3'd6), 10'd5, 4'd9, 0, 32'hffffffff, 0, 0, 0, 0));
        request_q.push_back(mk(act_t'(3'd7), 10'd5, 4'd9, 0, 32'hffffffff, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_CLEAR, 10'd3, 4'd11, 0, 0, 0, 0, 0, 0));
        request_q.push_back(mk(ACT_READ, 10'd5, 4'd9, 0, 0, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            // Gains for this phase, extremes first
            case (ph)
                0:
                begin
                    reg_write(REG_LEARN_RATE, 32'd65536);
                    reg_write(REG_DISCOUNT, 32'd0);
                    reg_write(REG_EXPLORE_RATE, 32'd0);
                end
                1:
                begin
                    reg_write(REG_LEARN_RATE, 32'd0);
                    reg_write(REG_DISCOUNT, 32'h0001ffff);
                    reg_write(REG_EXPLORE_RATE, 32'hfffe0000);
                end
                2:
                begin
                    reg_write(REG_LEARN_RATE, 32'd6554);
                    reg_write(REG_DISCOUNT, 32'd65535);
                    reg_write(REG_EXPLORE_RATE, 32'd65536);
                end
                default:
                begin
                    reg_write(REG_LEARN_RATE, $urandom);
                    reg_write(REG_DISCOUNT, $urandom_range(65536));
                    reg_write(REG_EXPLORE_RATE, $urandom_range(32768));
                end
            endcase
            send_idle = idle_tab[ph][0];
            recv_idle = idle_tab[ph][1];
            for (int n = 0; n < 330; n++)
                request_q.push_back(rand_request());
            // long receiver hold-off while requests keep coming
            if (ph == 1)
            begin
                repeat (20) @(posedge clk);
                recv_hold_len = 600;
            end
            wait_drained();
            // sender pauses after all responses are in, with gains untouched
            send_hold = 1'b1;
            repeat (5) @(posedge clk);
            send_hold = 1'b0;
        end

        wait_drained();
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
